// ===== hw/rtl/mcf_pkg.sv =====
package mcf_pkg;

   // Fixed field widths.
   localparam int CH_W       = 2;
   localparam int NUM_CH_MAX = 1 << CH_W;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = 40;
   localparam int FRAC_W     = 15;

   // Stream payload layout: channel in the low bits, sample above it.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int PAY_W      = CH_W + SAMPLE_W;
   localparam int PAD_W      = RSP_DATA_W - PAY_W;

   // Configuration registers.
   localparam int NUM_PACKS    = 4;
   localparam int PACK_W       = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int TAPS_W       = 5;
   localparam int CHANS_W      = 3;
   localparam int TAPS_RESET   = 16;
   localparam int CHANS_RESET  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PACK_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PACK_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS_IN_USE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANS_IN_USE  = 3'd5;

   // Request operation codes.
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // latch a filter request and start the tap walk
      logic clear;     // forget every channel history
      logic mac_step;  // one multiply for the current tap
      logic finish;    // round, load the output register, store the sample
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;   // the offered request is a clear
      logic active;     // the offered request is a filter on an active channel
      logic ntaps_zero; // no taps are applied
      logic last_tap;   // the current tap is the last one
      logic out_free;   // the output register can take a result this cycle
   } status_type;

endpackage

// ===== hw/rtl/mcf_ram.sv =====
module mcf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/mcf_ctrl.sv =====
module mcf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mcf_pkg::status_type status,
   output mcf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_ROUND = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_clear) begin
                  cmd.clear = 1'b1;
               end else if (status.active) begin
                  cmd.load = 1'b1;
                  state_in = status.ntaps_zero ? ST_ROUND : ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            if (status.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last product lands in the accumulator during this cycle.
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/mcf_datapath.sv =====
module mcf_datapath #(
   parameter int MAX_TAPS     = 16,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [mcf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  mcf_pkg::cmd_type                    cmd,
   output mcf_pkg::status_type                 status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [mcf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int HIST_LEN  = MAX_TAPS - 1;
   localparam int SLOT_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int AW        = mcf_pkg::CH_W + SLOT_W;
   localparam int DEPTH     = 1 << AW;
   localparam int TAP_W     = $clog2(MAX_TAPS);
   localparam int NT_W      = $clog2(MAX_TAPS + 1);
   localparam int CH_W      = mcf_pkg::CH_W;
   localparam int SAMPLE_W  = mcf_pkg::SAMPLE_W;
   localparam int COEF_W    = mcf_pkg::COEF_W;
   localparam int PROD_W    = mcf_pkg::PROD_W;
   localparam int ACC_W     = mcf_pkg::ACC_W;
   localparam int FRAC_W    = mcf_pkg::FRAC_W;
   localparam int Q_W       = ACC_W - FRAC_W;
   localparam int HI_W      = Q_W - SAMPLE_W + 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(HIST_LEN - 1);
   localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

   // Configuration registers.
   logic [mcf_pkg::PACK_W-1:0]  coef_pack_ff [mcf_pkg::NUM_PACKS];
   logic [mcf_pkg::TAPS_W-1:0]  taps_ff;
   logic [mcf_pkg::CHANS_W-1:0] chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcf_pkg::NUM_PACKS; i++) begin
            coef_pack_ff[i] <= '0;
         end
         taps_ff  <= mcf_pkg::TAPS_W'(mcf_pkg::TAPS_RESET);
         chans_ff <= mcf_pkg::CHANS_W'(mcf_pkg::CHANS_RESET);
      end else if (csr_we) begin
         if (csr_index <= mcf_pkg::CSR_COEF_PACK_3) begin
            coef_pack_ff[csr_index[1:0]] <= csr_wdata;
         end else if (csr_index == mcf_pkg::CSR_TAPS_IN_USE) begin
            taps_ff <= csr_wdata[mcf_pkg::TAPS_W-1:0];
         end else if (csr_index == mcf_pkg::CSR_CHANS_IN_USE) begin
            chans_ff <= csr_wdata[mcf_pkg::CHANS_W-1:0];
         end
      end
   end

   // Coefficients of the taps that exist.
   logic [COEF_W-1:0] coef [MAX_TAPS];

   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         coef[k] = coef_pack_ff[k / 4][COEF_W * (k % 4) +: COEF_W];
      end
   end

   // Offered request.
   logic [CH_W-1:0]     req_ch;
   logic [SAMPLE_W-1:0] req_sample;
   logic [NT_W-1:0]     ntaps_eff;

   assign req_ch     = req_tdata[CH_W-1:0];
   assign req_sample = req_tdata[CH_W +: SAMPLE_W];
   assign ntaps_eff  = (taps_ff > mcf_pkg::TAPS_W'(MAX_TAPS)) ? NT_W'(MAX_TAPS)
                                                              : NT_W'(taps_ff);

   // Working registers of the current item.
   logic [CH_W-1:0]          ch_ff;
   logic [SAMPLE_W-1:0]      x_ff;
   logic [NT_W-1:0]          ntaps_ff;
   logic [TAP_W-1:0]         tap_ff;
   logic [SLOT_W-1:0]        rd_ff;
   logic                     rd_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [SLOT_W-1:0]        wp_ff [mcf_pkg::NUM_CH_MAX];
   logic [DEPTH-1:0]         hist_vld_ff;
   logic                     rsp_valid_ff;
   logic [CH_W-1:0]          rsp_ch_ff;
   logic [SAMPLE_W-1:0]      rsp_sample_ff;

   logic [SLOT_W-1:0]        wp_cur;
   logic [SLOT_W-1:0]        wp_req;
   logic [AW-1:0]            raddr;
   logic [AW-1:0]            waddr;
   logic [SAMPLE_W-1:0]      ram_q;
   logic signed [SAMPLE_W-1:0] operand;
   logic signed [PROD_W-1:0] prod_in;
   logic [ACC_W-1:0]         rounded;
   logic [Q_W-1:0]           quot;
   logic [HI_W-1:0]          quot_hi;
   logic [SAMPLE_W-1:0]      sat_val;

   assign wp_cur = wp_ff[ch_ff];
   assign wp_req = wp_ff[req_ch];
   assign raddr  = {ch_ff, rd_ff};
   assign waddr  = {ch_ff, wp_cur};

   mcf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_hist_ram (
      .clock (clock),
      .we    (cmd.finish),
      .waddr (waddr),
      .wdata (x_ff),
      .re    (cmd.mac_step),
      .raddr (raddr),
      .rdata (ram_q)
   );

   // Tap zero takes the new sample; later taps take history, zero if never written.
   assign operand = (tap_ff == '0) ? $signed(x_ff)
                                   : (rd_vld_ff ? $signed(ram_q) : '0);
   assign prod_in = operand * $signed(coef[tap_ff]);

   // Round half up, floor shift, saturate to 16 bits.
   assign rounded = acc_ff + ROUND_HALF;
   assign quot    = rounded[ACC_W-1:FRAC_W];
   assign quot_hi = quot[Q_W-1:SAMPLE_W-1];

   always_comb begin
      if (!quot[Q_W-1] && (quot_hi != '0)) begin
         sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (quot[Q_W-1] && (quot_hi != '1)) begin
         sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_val = quot[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff    <= req_ch;
         x_ff     <= req_sample;
         ntaps_ff <= ntaps_eff;
         tap_ff   <= '0;
         rd_ff    <= (wp_req == '0) ? SLOT_LAST : wp_req - SLOT_W'(1);
      end else if (cmd.mac_step) begin
         tap_ff <= tap_ff + TAP_W'(1);
         rd_ff  <= (rd_ff == '0) ? SLOT_LAST : rd_ff - SLOT_W'(1);
      end
      if (cmd.mac_step) begin
         rd_vld_ff <= hist_vld_ff[raddr];
         prod_ff   <= prod_in;
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
      if (cmd.finish) begin
         rsp_ch_ff     <= ch_ff;
         rsp_sample_ff <= sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         hist_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < mcf_pkg::NUM_CH_MAX; c++) begin
            wp_ff[c] <= '0;
         end
      end else begin
         prod_vld_ff <= cmd.mac_step;
         if (cmd.clear) begin
            hist_vld_ff <= '0;
         end else if (cmd.finish) begin
            hist_vld_ff[waddr] <= 1'b1;
         end
         if (cmd.finish) begin
            wp_ff[ch_ff] <= (wp_cur == SLOT_LAST) ? '0 : wp_cur + SLOT_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.is_clear   = (req_tuser == mcf_pkg::OP_CLEAR);
   assign status.active     = (req_tuser == mcf_pkg::OP_FILTER)
                              && ({1'b0, req_ch} < chans_ff)
                              && (32'(req_ch) < NUM_CHANNELS);
   assign status.ntaps_zero = (ntaps_eff == '0);
   assign status.last_tap   = (NT_W'(tap_ff) == ntaps_ff - NT_W'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{mcf_pkg::PAD_W{1'b0}}, rsp_sample_ff, rsp_ch_ff};

endmodule

// ===== hw/rtl/multichannel_fir_filter_top.sv =====
// Direct-form filter for up to four interleaved audio channels with Q1.15
// samples and Q1.15 coefficients. Each filter request carries a channel and a
// sample; the block forms the sum of coefficient times sample over the taps in
// use, drawing older samples from that channel's own history, sums the
// products exactly in a 40-bit accumulator, rounds half up to Q1.15 and
// saturates. A clear request forgets all histories, and histories read as zero
// after reset. Requests for channels at or above the active channel count give
// no result and leave history alone. One shared 16x16 multiplier walks the
// taps one per cycle, with the tap count capped at MAX_TAPS. A filter request
// is accepted, takes one multiply per tap, drains the product register, then
// rounds and stores the sample, with no multiplies at zero taps; rounding
// waits while a full output register is not being read. A clear or ignored
// request is done when accepted. The result sits in an output register, so a
// new request is accepted while an earlier result waits.
// Histories live in one memory with a valid bit per entry, so a clear takes
// effect at once and no clearing pass follows reset.
module multichannel_fir_filter_top #(
   parameter int MAX_TAPS     = 16,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                               clock,
   input  logic                               reset,

   // Configuration: register index selects the coefficient packs, the tap
   // count or the channel count; writes complete in the cycle of csr_we.
   input  logic                               csr_we,
   input  logic [mcf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcf_pkg::CSR_DATA_W-1:0]     csr_wdata,

   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mcf_pkg::REQ_DATA_W-1:0]     req_tdata,  // channel, sample_in, zero pad
   input  logic                               req_tuser,  // op

   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mcf_pkg::RSP_DATA_W-1:0]     rsp_tdata   // out_channel, sample_out, zero pad
);

   // The controller sequences each request; the datapath holds the
   // configuration, the histories, the multiplier and the output register.
   mcf_pkg::cmd_type    cmd;
   mcf_pkg::status_type status;

   mcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mcf_datapath #(
      .MAX_TAPS     (MAX_TAPS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/multichannel_fir_filter_checker.sv =====
`timescale 1ns / 1ps

// Watches the register port and both streams and predicts every filtered sample.
// Results are compared in arrival order.
module multichannel_fir_filter_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [mcf_pkg::REQ_DATA_W-1:0] req_tdata,   // channel, sample_in, zero pad
   input  logic                           req_tuser,   // op
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [mcf_pkg::RSP_DATA_W-1:0] rsp_tdata,   // out_channel, sample_out, zero pad
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count
);

   localparam int CH_W       = mcf_pkg::CH_W;
   localparam int SAMPLE_W   = mcf_pkg::SAMPLE_W;
   localparam int COEF_W     = mcf_pkg::COEF_W;
   localparam int FRAC_W     = mcf_pkg::FRAC_W;
   localparam int PACK_W     = mcf_pkg::PACK_W;
   localparam int NUM_PACKS  = mcf_pkg::NUM_PACKS;
   localparam int TAPS_W     = mcf_pkg::TAPS_W;
   localparam int CHANS_W    = mcf_pkg::CHANS_W;
   localparam int NUM_CH_MAX = mcf_pkg::NUM_CH_MAX;

   localparam int TAP_LIMIT   = 16;
   localparam int HIST_DEPTH  = TAP_LIMIT - 1;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [SAMPLE_W-1:0] sample;
   } filtered_sample_type;

   logic [PACK_W-1:0]          coef_pack [NUM_PACKS];
   logic [TAPS_W-1:0]          taps_cfg;
   logic [CHANS_W-1:0]         chans_cfg;
   logic signed [SAMPLE_W-1:0] history [NUM_CH_MAX][HIST_DEPTH];
   filtered_sample_type        pending_outputs [$];
   filtered_sample_type        got;
   filtered_sample_type        want;
   logic [CH_W-1:0]            req_channel;
   logic signed [SAMPLE_W-1:0] req_sample;
   int                         active_channels;

   function automatic void forget_history();
      for (int c = 0; c < NUM_CH_MAX; c++)
         for (int i = 0; i < HIST_DEPTH; i++)
            history[c][i] = '0;
   endfunction

   // Sums the products exactly, rounds half up to Q1.15, saturates, and then
   // pushes the new sample into the channel history.
   function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic [CH_W-1:0]            ch,
      input logic signed [SAMPLE_W-1:0] x
   );
      longint                     acc;
      longint                     rounded;
      int                         ntaps;
      logic signed [COEF_W-1:0]   coef;
      logic signed [SAMPLE_W-1:0] tap_in;
      ntaps = (taps_cfg > TAP_LIMIT) ? TAP_LIMIT : int'(taps_cfg);
      acc = 0;
      for (int k = 0; k < ntaps; k++) begin
         coef = coef_pack[k / 4][16 * (k % 4) +: COEF_W];
         if (k == 0) begin
            tap_in = x;
         end else begin
            tap_in = history[ch][k - 1];
         end
         acc = acc + longint'(coef) * longint'(tap_in);
      end
      rounded = (acc + 16384) >>> FRAC_W;
      if (rounded > 32767) begin
         rounded = 32767;
      end else if (rounded < -32768) begin
         rounded = -32768;
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--)
         history[ch][i] = history[ch][i - 1];
      history[ch][0] = x;
      return rounded[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PACKS; i++)
            coef_pack[i] = '0;
         taps_cfg  = TAPS_W'(mcf_pkg::TAPS_RESET);
         chans_cfg = CHANS_W'(mcf_pkg::CHANS_RESET);
         forget_history();
         pending_outputs.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index <= mcf_pkg::CSR_COEF_PACK_3) begin
               coef_pack[csr_index - mcf_pkg::CSR_COEF_PACK_0] = csr_wdata;
            end else if (csr_index == mcf_pkg::CSR_TAPS_IN_USE) begin
               taps_cfg = csr_wdata[TAPS_W-1:0];
            end else if (csr_index == mcf_pkg::CSR_CHANS_IN_USE) begin
               chans_cfg = csr_wdata[CHANS_W-1:0];
            end
         end

         if (req_tvalid && req_tready) begin
            req_channel = req_tdata[CH_W-1:0];
            req_sample  = req_tdata[CH_W +: SAMPLE_W];
            active_channels = (chans_cfg > NUM_CH_MAX) ? NUM_CH_MAX
                                                       : int'(chans_cfg);
            if (req_tuser == mcf_pkg::OP_CLEAR) begin
               forget_history();
            end else if (req_channel < active_channels) begin
               want.channel = req_channel;
               want.sample  = filter_sample(req_channel, req_sample);
               pending_outputs.push_back(want);
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got.channel = rsp_tdata[CH_W-1:0];
            got.sample  = rsp_tdata[CH_W +: SAMPLE_W];
            checked_count++;
            if (pending_outputs.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("Unexpected result: channel %0d sample %0d",
                           got.channel, $signed(got.sample));
            end else begin
               want = pending_outputs.pop_front();
               if (got.channel !== want.channel || got.sample !== want.sample) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"Result %0d: expected channel %0d sample %0d, ",
                               "got channel %0d sample %0d"},
                              checked_count, want.channel, $signed(want.sample),
                              got.channel, $signed(got.sample));
               end
            end
         end
      end
      pending_count = pending_outputs.size();
   end

endmodule

// ===== tb/tb_multichannel_fir_filter_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the multichannel filter. The checker instance does
// all prediction and comparison; this module only drives requests, register
// writes and result back-pressure, and reports the outcome.
module tb_multichannel_fir_filter_top;

   localparam int CSR_IDX_W  = mcf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = mcf_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W = mcf_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = mcf_pkg::RSP_DATA_W;
   localparam int CH_W       = mcf_pkg::CH_W;
   localparam int SAMPLE_W   = mcf_pkg::SAMPLE_W;
   localparam int PACK_W     = mcf_pkg::PACK_W;
   localparam int NUM_PACKS  = mcf_pkg::NUM_PACKS;
   localparam int NUM_CH_MAX = mcf_pkg::NUM_CH_MAX;

   localparam int IDLE_PERCENT       = 19;
   localparam int CLEAR_PERCENT      = 4;
   localparam int LONG_HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES       = 40;    // outlasts any request still in flight
   localparam int RANDOM_PHASES      = 12;
   localparam int REQUESTS_PER_PHASE = 135;
   localparam int TIMEOUT_NS         = 5_000_000;

   // Indexes that decode to no register; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // channel, sample_in, zero pad
   logic                  req_tuser  = 1'b0; // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_channel, sample_out, zero pad

   int fail_count;
   int pending_count;
   int checked_count;

   // When set, neither side inserts random idle cycles.
   logic quiet_stretch = 1'b0;

   // The stimulus bumps hold_requests; the receiver process notices the
   // difference and then holds rsp_tready low while hold_left counts down from LONG_HOLD_CYCLES.
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int active_channels = mcf_pkg::CHANS_RESET;
   int filter_count    = 0;
   int clear_count     = 0;
   int ignored_count   = 0;
   int setting_count   = 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multichannel_fir_filter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   multichannel_fir_filter_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Result receiver. It stalls at random, except during a quiet stretch, and
   // serves long hold-offs so that the output register and the datapath fill
   // up and the block has to push back on its request stream.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_tready  <= 1'b0;
         hold_left   <= LONG_HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Mostly full-range samples, with the extremes, zero and small values
   // mixed in so that rounding near zero is exercised too.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3, 4:    return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // Four coefficients in one register: full range, small, all +max or all -1.0.
   // The two uniform styles push the accumulator into saturation.
   function automatic logic [PACK_W-1:0] pick_pack(input int style);
      logic [PACK_W-1:0] coefs;
      for (int i = 0; i < 4; i++) begin
         case (style)
            0, 1:    coefs[16*i +: 16] = 16'($urandom);
            2, 3:    coefs[16*i +: 16] = 16'($urandom_range(0, 8191) - 4096);
            4:       coefs[16*i +: 16] = 16'h7FFF;
            default: coefs[16*i +: 16] = 16'h8000;
         endcase
      end
      return coefs;
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   // The valid line is left high so that back-to-back requests need no
   // second assignment in the same time step; idle cycles lower it.
   task automatic send_request(
      input logic                       op,
      input logic [CH_W-1:0]            ch,
      input logic signed [SAMPLE_W-1:0] smp
   );
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - CH_W - SAMPLE_W){1'b0}}, smp, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == mcf_pkg::OP_CLEAR) begin
         clear_count++;
      end else if (ch < active_channels) begin
         filter_count++;
      end else begin
         ignored_count++;
      end
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_csr(
      input logic [CSR_IDX_W-1:0]  idx,
      input logic [CSR_DATA_W-1:0] data
   );
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes every register, plus junk to the unmapped indexes. Only called
   // while the block is idle.
   task automatic program_filter(
      input logic [NUM_PACKS*PACK_W-1:0] packs,
      input int                          taps,
      input int                          chans
   );
      for (int i = 0; i < NUM_PACKS; i++)
         write_csr(mcf_pkg::CSR_COEF_PACK_0 + CSR_IDX_W'(i),
                   packs[i*PACK_W +: PACK_W]);
      write_csr(mcf_pkg::CSR_TAPS_IN_USE, 64'(taps));
      write_csr(mcf_pkg::CSR_CHANS_IN_USE, 64'(chans));
      write_csr(CSR_UNMAPPED_LO, {$urandom, $urandom});
      write_csr(CSR_UNMAPPED_HI, {$urandom, $urandom});
      csr_we <= 1'b0;
      @(negedge clock);
      active_channels = (chans > NUM_CH_MAX) ? NUM_CH_MAX : chans;
      setting_count++;
   endtask

   // Waits for every predicted result, then lets a clear or ignored request
   // that may still be in flight finish before the registers change.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [NUM_PACKS*PACK_W-1:0] packs;
      int                          taps;
      int                          chans;
      int                          start_count;
      logic                        op;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset registers: coefficients are zero, so every channel reads zero
      // while each history takes one extreme or near-zero sample.
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh7FFF);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'sh8000);
      send_request(mcf_pkg::OP_FILTER, 2'd2, 16'sh0001);
      send_request(mcf_pkg::OP_FILTER, 2'd3, 16'shFFFF);
      wait_until_idle();

      // Mixed extreme coefficients on all sixteen taps; a clear in the middle
      // must make the next sample see an empty history.
      program_filter({64'h1357_9BDF_2468_ACE0, 64'h0F0F_F0F0_00FF_FF00,
                      64'h0001_FFFF_0100_FF00, 64'hC000_4000_8000_7FFF}, 16, 4);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh7FFF);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh8000);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'sh0001);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'shFFFF);
      send_request(mcf_pkg::OP_FILTER, 2'd2, 16'sh0000);
      send_request(mcf_pkg::OP_FILTER, 2'd3, 16'sh7FFF);
      send_request(mcf_pkg::OP_CLEAR,  2'd2, 16'sh1234);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh8000);
      wait_until_idle();

      // All coefficients at +max: repeated full-scale samples saturate in
      // both directions.
      program_filter({NUM_PACKS{pick_pack(4)}}, 16, 4);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh7FFF);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh7FFF);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'sh8000);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'sh8000);
      wait_until_idle();

      // One tap of -1.0 times -1.0 overflows Q1.15 on its own. Only two
      // channels are active, so the upper two are ignored.
      program_filter({NUM_PACKS{pick_pack(5)}}, 1, 2);
      send_request(mcf_pkg::OP_FILTER, 2'd1, 16'sh8000);
      send_request(mcf_pkg::OP_FILTER, 2'd0, 16'sh7FFF);
      send_request(mcf_pkg::OP_FILTER, 2'd3, 16'sh0005);
      send_request(mcf_pkg::OP_FILTER, 2'd2, 16'shFFFB);
      wait_until_idle();

      // Zero taps give zero output but still shift the history; a channel
      // count above the channels present acts as all of them.
      program_filter({pick_pack(0), pick_pack(1), pick_pack(2), pick_pack(3)}, 0, 7);
      for (int c = 0; c < NUM_CH_MAX; c++)
         send_request(mcf_pkg::OP_FILTER, CH_W'(c), pick_sample());
      wait_until_idle();

      // A channel count of zero ignores every sample and keeps the histories; the
      // oversized tap count goes unused here, as no sample is filtered.
      program_filter({pick_pack(0), pick_pack(2), pick_pack(0), pick_pack(2)}, 31, 0);
      send_request(mcf_pkg::OP_FILTER, 2'd0, pick_sample());
      send_request(mcf_pkg::OP_FILTER, 2'd3, pick_sample());
      wait_until_idle();

      // Random phases. Fixed settings first cover the corners, then random
      // ones. Every request sent, ignored or not, counts toward a phase's quota.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin taps = 16; chans = 4; end
            1:       begin taps = 1;  chans = 1; end
            2:       begin taps = 9;  chans = 3; end
            3:       begin taps = 0;  chans = 4; end
            4:       begin taps = 31; chans = 7; end
            5:       begin taps = 12; chans = 2; end
            6:       begin taps = 16; chans = 4; end
            7:       begin taps = 3;  chans = 5; end
            8:       begin taps = 17; chans = 4; end
            default: begin taps = $urandom_range(0, 31); chans = $urandom_range(0, 7); end
         endcase
         for (int i = 0; i < NUM_PACKS; i++)
            packs[i*PACK_W +: PACK_W] = pick_pack($urandom_range(0, 5));
         program_filter(packs, taps, chans);

         // One phase runs with no idling at all on either side, and one
         // starts with a long receiver hold-off while requests keep coming.
         if (phase == 2)
            quiet_stretch <= 1'b1;
         if (phase == 5)
            hold_requests <= hold_requests + 1;

         start_count = filter_count + clear_count + ignored_count;
         if (active_channels == 0) begin
            repeat (12) send_request(mcf_pkg::OP_FILTER,
                                     CH_W'($urandom_range(0, NUM_CH_MAX - 1)),
                                     pick_sample());
         end else begin
            while (filter_count + clear_count + ignored_count - start_count
                   < REQUESTS_PER_PHASE) begin
               op = ($urandom_range(0, 99) < CLEAR_PERCENT) ? mcf_pkg::OP_CLEAR
                                                            : mcf_pkg::OP_FILTER;
               send_request(op, CH_W'($urandom_range(0, NUM_CH_MAX - 1)), pick_sample());
            end
         end
         wait_until_idle();
         quiet_stretch <= 1'b0;
      end

      $display("Run covered %0d filter requests, %0d clears and %0d ignored requests",
               filter_count, clear_count, ignored_count);
      $display("over %0d register settings; %0d results compared, %0d failures.",
               setting_count, checked_count, fail_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hung handshake or a result that never shows up.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results still outstanding", pending_count);
      $display("Some tests failed");
      $finish;
   end

endmodule
